// ----- rtl/rct_pkg.sv -----
// Package for the radial chirp test pattern: widths, register indexes,
// reset values, cosine constants and the structs that travel down the cell chains.
// No dependencies.
package rct_pkg;

    localparam int SIDE_W  = 10;
    localparam int WAVE_W  = 9;
    localparam int COORD_W = 10;
    localparam int GRAY_W  = 8;
    localparam int CFG_W   = 10;

    localparam int RAD_W   = 36;   // radicand, two bits consumed per sqrt cell
    localparam int REM_W   = 20;   // sqrt partial remainder
    localparam int ROOT_W  = 18;   // sqrt result
    localparam int RF_W    = 17;   // radius, 8 fraction bits
    localparam int DNUM_W  = 33;   // dividend shifted out one bit per divider cell
    localparam int DDEN_W  = 17;   // divisor
    localparam int DREM_W  = 18;   // divider partial remainder
    localparam int DQUO_W  = 17;   // quotient bits kept

    localparam int SQRT_CELLS = RAD_W / 2;
    localparam int DIV1_CELLS = 17;
    localparam int DIV2_CELLS = DNUM_W;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 10'd599;
    localparam logic [WAVE_W-1:0] MINW_RESET = 9'd1;
    localparam logic [WAVE_W-1:0] MAXW_RESET = 9'd299;

    localparam logic [11:0] COS_C = 12'd2320;
    localparam logic [14:0] COS_B = 15'd21024;
    localparam logic [15:0] COS_A = 16'd51472;

    typedef enum logic [1:0] {
        REG_SIDE_LENGTH    = 2'd0,
        REG_MIN_WAVELENGTH = 2'd1,
        REG_MAX_WAVELENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic            vld;
        logic            ins;
        logic [RF_W-1:0] rf;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        side_t             side;
        logic [DREM_W-1:0] rem;
        logic [DNUM_W-1:0] num;
        logic [DDEN_W-1:0] den;
        logic [DQUO_W-1:0] quo;
    } div_t;

endpackage

// ----- rtl/radial_chirp_test_pattern.sv -----
// Radial chirp test pattern top level: one gray pixel per (col,row) transfer.
// A pixel passes stages A to C, 18 square-root cells, stage D, 17 divider cells, stage E,
// 33 divider cells, the shade stages and the output register. Depends on rct_pkg,
// rct_sqrt_cell, rct_div_cell and rct_shade. Throughput: one pixel per clock while the skid
// is empty; a one-entry skid behind the output register catches a result, then stalls input.
// Reset (aresetn low, synchronous) empties the pipeline and loads side 599, min 1, max 299.
module radial_chirp_test_pattern (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [rct_pkg::CFG_W-1:0]   cfg_wdata,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // col [9:0], row [19:10], zero [23:20]
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // gray [7:0]
);
    import rct_pkg::*;

    // ---------------- configuration registers ----------------
    logic [SIDE_W-1:0] side_reg;
    logic [WAVE_W-1:0] minw_reg;
    logic [WAVE_W-1:0] maxw_reg;
    logic [19:0]       cm1sq_reg;   // (side-1)^2, or 1 for an empty image

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_RESET;
            minw_reg <= MINW_RESET;
            maxw_reg <= MAXW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SIDE_LENGTH:    side_reg <= cfg_wdata[SIDE_W-1:0];
                REG_MIN_WAVELENGTH: minw_reg <= cfg_wdata[WAVE_W-1:0];
                REG_MAX_WAVELENGTH: maxw_reg <= cfg_wdata[WAVE_W-1:0];
                default: ;   // index beyond the register list: drop
            endcase
        end
    end

    // derived settings: the user keeps them stable while pixels are in flight; unenforced
    logic [SIDE_W-1:0] cm1;
    logic              cm1_zero;
    logic              d_neg;
    logic [WAVE_W-1:0] ad;

    assign cm1      = side_reg - 10'd1;
    assign cm1_zero = (side_reg == 10'd1);
    assign d_neg    = (minw_reg > maxw_reg);
    assign ad       = d_neg ? minw_reg - maxw_reg : maxw_reg - minw_reg;

    always_ff @(posedge aclk) begin
        cm1sq_reg <= (side_reg == '0) ? 20'd1 : cm1 * cm1;
    end

    // ---------------- pipeline control ----------------
    // The whole chain advances unless the skid holds a result.
    logic ce;
    logic out_vld_reg;
    logic [GRAY_W-1:0] out_gray_reg;
    logic skid_vld_reg;
    logic [GRAY_W-1:0] skid_gray_reg;

    assign ce       = !skid_vld_reg;
    assign s_tready = ce;

    // ---------------- stage A: absolute doubled offsets ----------------
    logic              a_vld_reg;
    logic [10:0]       adx_reg, ady_reg;
    logic [12:0]       dx, dy;

    assign dx = {3'b000, side_reg} - 13'd1 - {2'b00, s_tdata[9:0], 1'b0};
    assign dy = {3'b000, side_reg} - 13'd1 - {2'b00, s_tdata[19:10], 1'b0};

    // ---------------- stage B: squares ----------------
    logic              b_vld_reg;
    logic [21:0]       sx_reg, sy_reg;

    // ---------------- stage C: inside test, sqrt chain head ----------------
    logic [22:0]       s2;
    logic              in_circle;
    sqrt_t             sq_head_reg;
    sqrt_t             sq_chain [SQRT_CELLS+1];

    assign s2        = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign in_circle = (s2 <= {3'b000, cm1sq_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg             <= 1'b0;
            b_vld_reg             <= 1'b0;
            sq_head_reg.side.vld  <= 1'b0;
        end else if (ce) begin
            a_vld_reg             <= s_tvalid;
            b_vld_reg             <= a_vld_reg;
            sq_head_reg.side.vld  <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            adx_reg <= dx[12] ? 11'(-dx) : dx[10:0];
            ady_reg <= dy[12] ? 11'(-dy) : dy[10:0];
            sx_reg  <= adx_reg * adx_reg;
            sy_reg  <= ady_reg * ady_reg;
            sq_head_reg.side.ins <= in_circle;
            sq_head_reg.side.rf  <= '0;
            // radicand = s2 << 14; zero outside the circle
            sq_head_reg.rad  <= in_circle ? {1'b0, s2[20:0], 14'b0} : '0;
            sq_head_reg.rem  <= '0;
            sq_head_reg.root <= '0;
        end
    end

    assign sq_chain[0] = sq_head_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
        rct_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .cell_in  (sq_chain[i]),
            .cell_out (sq_chain[i+1])
        );
    end

    // ---------------- stage D: numerator of the wavelength slope ----------------
    side_t        d_side_reg;
    logic [25:0]  n1_reg;
    div_t         dv1_chain [DIV1_CELLS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_side_reg.vld <= 1'b0;
        end else if (ce) begin
            d_side_reg.vld <= sq_chain[SQRT_CELLS].side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_side_reg.ins <= sq_chain[SQRT_CELLS].side.ins;
            d_side_reg.rf  <= sq_chain[SQRT_CELLS].root[RF_W-1:0];
            n1_reg         <= ad * sq_chain[SQRT_CELLS].root[RF_W-1:0];
        end
    end

    // q = (2*ad*rf) / (side-1); upper bits preload the remainder
    always_comb begin
        dv1_chain[0].side = d_side_reg;
        dv1_chain[0].rem  = {8'b0, n1_reg[25:16]};
        dv1_chain[0].num  = {n1_reg[15:0], 1'b0, 16'b0};
        dv1_chain[0].den  = {7'b0, cm1};
        dv1_chain[0].quo  = '0;
    end

    for (genvar i = 0; i < DIV1_CELLS; i++) begin : g_div1
        rct_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .cell_in  (dv1_chain[i]),
            .cell_out (dv1_chain[i+1])
        );
    end

    // ---------------- stage E: local wavelength ----------------
    side_t             e_side_reg;
    logic [DDEN_W-1:0] lf_reg;
    logic [DQUO_W-1:0] q;
    logic [18:0]       base;
    logic [18:0]       lf_s;
    div_t              dv2_chain [DIV2_CELLS+1];

    assign q    = cm1_zero ? '0 : dv1_chain[DIV1_CELLS].quo;
    assign base = {2'b00, maxw_reg, 8'b0};
    assign lf_s = d_neg ? base + {2'b00, q} : base - {2'b00, q};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_side_reg.vld <= 1'b0;
        end else if (ce) begin
            e_side_reg.vld <= dv1_chain[DIV1_CELLS].side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_side_reg.ins <= dv1_chain[DIV1_CELLS].side.ins;
            e_side_reg.rf  <= dv1_chain[DIV1_CELLS].side.rf;
            // raise a zero or negative wavelength to 1/256 pixel
            lf_reg <= (lf_s[18] || lf_s == '0) ? DDEN_W'(1) : lf_s[DDEN_W-1:0];
        end
    end

    // phase = (rf << 16) / lf, low 16 bits kept
    always_comb begin
        dv2_chain[0].side = e_side_reg;
        dv2_chain[0].rem  = '0;
        dv2_chain[0].num  = {e_side_reg.rf, 16'b0};
        dv2_chain[0].den  = lf_reg;
        dv2_chain[0].quo  = '0;
    end

    for (genvar i = 0; i < DIV2_CELLS; i++) begin : g_div2
        rct_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .cell_in  (dv2_chain[i]),
            .cell_out (dv2_chain[i+1])
        );
    end

    // ---------------- cosine and gray scaling ----------------
    logic              sh_vld;
    logic [GRAY_W-1:0] sh_gray;

    rct_shade u_shade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_side  (dv2_chain[DIV2_CELLS].side),
        .in_phase (dv2_chain[DIV2_CELLS].quo[15:0]),
        .out_vld  (sh_vld),
        .out_gray (sh_gray)
    );

    // ---------------- output register and skid ----------------
    // A result lands in the output register when it is free or being taken,
    // otherwise in the skid, which then stalls the chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_tready) begin
            out_vld_reg <= sh_vld;
        end else if (sh_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_gray_reg <= skid_gray_reg;
            end
        end else if (!out_vld_reg || m_tready) begin
            out_gray_reg <= sh_gray;
        end else begin
            skid_gray_reg <= sh_gray;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_gray_reg;

endmodule

// ----- rtl/rct_sqrt_cell.sv -----
// One cell of the square-root chain: one root bit per cell, digit recurrence.
// Depends on rct_pkg.
module rct_sqrt_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  rct_pkg::sqrt_t cell_in,
    output rct_pkg::sqrt_t cell_out
);
    import rct_pkg::*;

    sqrt_t               cell_reg;
    sqrt_t               cell_next;
    logic [REM_W+1:0]    t;
    logic [REM_W+1:0]    trial;

    always_comb begin
        t = {cell_in.rem, cell_in.rad[RAD_W-1:RAD_W-2]};
        trial = {2'b00, cell_in.root, 2'b01};
        cell_next = cell_in;
        cell_next.rad = {cell_in.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            cell_next.rem  = REM_W'(t - trial);
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = t[REM_W-1:0];
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.side.vld <= 1'b0;
        end else if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- rtl/rct_div_cell.sv -----
// One cell of a restoring divider chain: one quotient bit per cell.
// Depends on rct_pkg.
module rct_div_cell (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  rct_pkg::div_t cell_in,
    output rct_pkg::div_t cell_out
);
    import rct_pkg::*;

    div_t              cell_reg;
    div_t              cell_next;
    logic [DREM_W:0]   t;
    logic [DREM_W:0]   den_x;

    always_comb begin
        t = {cell_in.rem, cell_in.num[DNUM_W-1]};
        den_x = {2'b00, cell_in.den};
        cell_next = cell_in;
        cell_next.num = {cell_in.num[DNUM_W-2:0], 1'b0};
        if (t >= den_x) begin
            cell_next.rem = DREM_W'(t - den_x);
            cell_next.quo = {cell_in.quo[DQUO_W-2:0], 1'b1};
        end else begin
            cell_next.rem = t[DREM_W-1:0];
            cell_next.quo = {cell_in.quo[DQUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.side.vld <= 1'b0;
        end else if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- rtl/rct_shade.sv -----
// Phase to gray value: quarter-wave polynomial cosine, then scale to 0..255.
// Depends on rct_pkg.
module rct_shade (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  rct_pkg::side_t              in_side,
    input  logic [15:0]                 in_phase,
    output logic                        out_vld,
    output logic [rct_pkg::GRAY_W-1:0]  out_gray
);
    import rct_pkg::*;

    logic [6:0]  vld_reg;
    logic [5:0]  ins_reg;
    logic [4:0]  neg_reg;
    logic [14:0] u1_reg, u2s_reg, u3_reg, u4_reg;
    logic [29:0] uu_reg;
    logic [14:0] sq3_reg;
    logic [26:0] t_reg;
    logic [29:0] m_reg;
    logic [30:0] r_reg;
    logic [23:0] y_reg;
    logic [GRAY_W-1:0] gray_reg;

    logic [14:0] u_next;
    logic [14:0] inner;
    logic [15:0] mid;
    logic [16:0] res;
    logic [14:0] res_sat;
    logic [15:0] x;
    logic [16:0] rr;
    logic [8:0]  g;

    always_comb begin
        // odd quadrants use f directly, even ones mirror it
        u_next  = in_phase[14] ? {1'b0, in_phase[13:0]} : 15'd16384 - {1'b0, in_phase[13:0]};
        inner   = COS_B - {2'b00, t_reg[26:14]};
        mid     = COS_A - m_reg[29:14];
        res     = r_reg[30:14];
        res_sat = (res > 17'd32767) ? 15'd32767 : res[14:0];
        x       = neg_reg[4] ? 16'd32767 - {1'b0, res_sat} : 16'd32767 + {1'b0, res_sat};
        // y / 65534 is y >> 16 or one more
        rr      = {1'b0, y_reg[15:0]} + {8'b0, y_reg[23:16], 1'b0};
        g       = {1'b0, y_reg[23:16]} + ((rr >= 17'd65534) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[5:0], in_side.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ins_reg  <= {ins_reg[4:0], in_side.ins};
            neg_reg  <= {neg_reg[3:0], in_phase[15] ^ in_phase[14]};
            u1_reg   <= u_next;
            uu_reg   <= u1_reg * u1_reg;
            u2s_reg  <= u1_reg;
            sq3_reg  <= uu_reg[28:14];
            t_reg    <= COS_C * uu_reg[28:14];
            u3_reg   <= u2s_reg;
            m_reg    <= inner * sq3_reg;
            u4_reg   <= u3_reg;
            r_reg    <= mid * u4_reg;
            y_reg    <= {x, 8'b0} - {8'b0, x};
            gray_reg <= !ins_reg[5] ? '0 : (g[8] ? 8'd255 : g[7:0]);
        end
    end

    assign out_vld  = vld_reg[6];
    assign out_gray = gray_reg;

endmodule

// ----- rtl/rct_checker.sv -----
// Port-level checks for the radial chirp test pattern, bound to the top level.
// Depends on radial_chirp_test_pattern.
module rct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // input stalls only behind a waiting result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // skid fills only when the output was blocked
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without backpressure");

endmodule

bind radial_chirp_test_pattern rct_checker u_rct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
// Testbench for radial_chirp_test_pattern: streams pixel coordinates, predicts each
// gray value with a bit-exact fixed-point model and checks the result stream.
// Depends on rct_pkg and the radial_chirp_test_pattern RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rct_pkg::*;

    // Scoreboard: holds the register copy and the queue of predicted gray values.
    class gray_scoreboard;
        int unsigned side_len = 599;
        int unsigned min_wave = 1;
        int unsigned max_wave = 299;
        logic [7:0]  gray_q[$];
        int          errors = 0;
        int          checked = 0;

        function void set_reg(cfg_reg_t idx, int unsigned val);
            case (idx)
                REG_SIDE_LENGTH:    side_len = val & 10'h3FF;
                REG_MIN_WAVELENGTH: min_wave = val & 9'h1FF;
                REG_MAX_WAVELENGTH: max_wave = val & 9'h1FF;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint quarter_sin(longint u);
            longint u2, inner, mid, res;
            u2 = (u * u) >>> 14;
            inner = 21024 - ((2320 * u2) >>> 14);
            mid = 51472 - ((inner * u2) >>> 14);
            res = (mid * u) >>> 14;
            if (res > 32767) res = 32767;
            return res;
        endfunction

        function logic [7:0] pixel_gray(int unsigned col, int unsigned row);
            longint cm1, dx, dy, s2, dw, lf, c, g;
            longint unsigned rf, ad, den, q;
            logic [15:0] ph;
            cm1 = longint'(side_len) - 1;
            dx = cm1 - 2 * longint'(col);
            dy = cm1 - 2 * longint'(row);
            s2 = dx * dx + dy * dy;
            if (s2 > cm1 * cm1) return 8'd0;
            rf = root_floor(longint'(s2) << 14);
            dw = longint'(max_wave) - longint'(min_wave);
            ad = (dw < 0) ? -dw : dw;
            den = (cm1 > 0) ? (longint'(cm1) << 8) : 0;
            q = (den == 0) ? 0 : (ad * rf * 512) / den;
            lf = longint'(max_wave) * 256;
            lf = (dw >= 0) ? lf - longint'(q) : lf + longint'(q);
            if (lf < 1) lf = 1;
            ph = 16'((rf << 24) / (longint'(lf) << 8));
            case (ph[15:14])
                2'd0: c = quarter_sin(16384 - ph[13:0]);
                2'd1: c = -quarter_sin(ph[13:0]);
                2'd2: c = -quarter_sin(16384 - ph[13:0]);
                default: c = quarter_sin(ph[13:0]);
            endcase
            g = (255 * (c + 32767)) / 65534;
            if (g < 0) g = 0;
            if (g > 255) g = 255;
            return 8'(g);
        endfunction

        function void note_pixel(logic [23:0] data);
            gray_q.push_back(pixel_gray(data[9:0], data[19:10]));
        endfunction

        function void check_gray(logic [7:0] got);
            logic [7:0] want;
            if (gray_q.size() == 0) begin
                $display("%0t: unexpected gray transfer, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = gray_q.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: gray mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    gray_scoreboard sb = new();
    bit          no_idle = 1'b0;    // long stretch with both sides always active
    int          n_sent = 0;
    int          n_phases = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    radial_chirp_test_pattern u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Receiver: stall at random about 9 percent of the time; check each accepted transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_gray(m_tdata);
            m_tready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    // Write one register while the pipeline is idle.
    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 10'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Send one pixel; hold tvalid until the transfer, idle at random afterwards.
    task automatic send_pixel(int unsigned col, int unsigned row);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 10'(row), 10'(col)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pixel({4'b0, 10'(row), 10'(col)});
        n_sent++;
        if (!no_idle && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Drain: drop tvalid, wait for every prediction, then cover the latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.gray_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Random pixel, mostly within the image, sometimes anywhere in the field.
    task automatic random_pixel();
        int unsigned lim;
        lim = (sb.side_len > 0) ? sb.side_len - 1 : 0;
        if ($urandom_range(9) == 0) send_pixel($urandom_range(1023), $urandom_range(1023));
        else send_pixel($urandom_range(lim), $urandom_range(lim));
    endtask

    initial begin
        int unsigned sides[8] = '{599, 3, 1023, 64, 1, 0, 257, 31};
        int unsigned mins[8]  = '{1, 511, 1, 300, 0, 5, 511, 2};
        int unsigned maxs[8]  = '{299, 1, 511, 10, 0, 200, 0, 511};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, center, corners, edges, outside the image.
        send_pixel(299, 299);
        send_pixel(0, 0);
        send_pixel(598, 598);
        send_pixel(0, 299);
        send_pixel(299, 598);
        send_pixel(1023, 1023);
        send_pixel(1022, 0);
        send_pixel(600, 299);
        send_pixel(300, 299);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain();

        // Phases: each setting, extremes among them, then random pixels.
        for (int ph = 0; ph < 10; ph++) begin
            int unsigned sv, mn, mx;
            if (ph < 8) begin
                sv = sides[ph]; mn = mins[ph]; mx = maxs[ph];
            end else begin
                sv = $urandom_range(1023, 3);
                mn = $urandom_range(511);
                mx = $urandom_range(511);
            end
            write_reg(REG_SIDE_LENGTH, sv);
            write_reg(REG_MIN_WAVELENGTH, mn);
            write_reg(REG_MAX_WAVELENGTH, mx);
            n_phases++;
            // Even side, side one, side zero: center and origin pixels.
            send_pixel((sv > 0) ? (sv - 1) / 2 : 0, (sv > 0) ? (sv - 1) / 2 : 0);
            send_pixel(0, 0);
            no_idle = (ph == 2);
            repeat (140) random_pixel();
            no_idle = 1'b0;
            drain();
        end

        $display("Covered %0d pixels over %0d register settings, %0d results checked.",
                 n_sent, n_phases + 1, sb.checked);
        if (sb.errors == 0 && sb.gray_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- radial_chirp_test_pattern.f -----
rtl/rct_pkg.sv
rtl/rct_sqrt_cell.sv
rtl/rct_div_cell.sv
rtl/rct_shade.sv
rtl/radial_chirp_test_pattern.sv
rtl/rct_checker.sv
verif/tb.sv
